### src/ear_pkg.sv
// Package for euler_angles_to_rotation: widths, CORDIC constants, cell types.
// No dependencies.
package ear_pkg;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
    localparam int PIPE_DEPTH   = CORDIC_STEPS + 5;   // input stage, cells, four matrix stages
    localparam int OUT_BITS     = 16;
    localparam int CW           = 34;   // Q2.30 datapath plus guard bits
    localparam int SCW          = 22;   // Q20 sine/cosine, signed

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [CW-1:0]  t_cw;
    typedef logic signed [SCW-1:0] t_sc;

    typedef struct packed {
        t_cw  x;
        t_cw  y;
        t_cw  z;
        logic neg;
    } t_rot;

    typedef struct packed {
        t_rot roll;
        t_rot pitch;
        t_rot yaw;
    } t_cell;

    function automatic t_cw atan_q30(input int i);
        t_cw v;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = (i < 30) ? t_cw'(34'sd1 <<< (30 - i)) : '0;
        endcase
        return v;
    endfunction
endpackage

### src/ear_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface ear_if #(parameter int W = 48);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/euler_angles_to_rotation.sv
// Channel | Dir | Payload
// angles  | in  | roll, pitch, yaw (Q2.13 each)
// matrix  | out | r00..r22 (Q1.14 each)
// Throughput one triple per cycle while the output does not stall; data passes through the
// input stage, the cell row and four matrix stages. The whole pipe advances when
// the output is free or taken; a stall freezes every stage. Reset clears the
// valid bits only and holds the input ready low.
// Depends on ear_pkg, ear_if, ear_cell, ear_mat.
module euler_angles_to_rotation import ear_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ear_if.sink   i_ang,
    ear_if.source o_mat
);
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  adv;
    t_cell                 r_prep;
    t_cell                 cells [CORDIC_STEPS+1];

    assign adv         = !r_vld[PIPE_DEPTH-1] || o_mat.ready;
    assign i_ang.ready = adv && i_rst_n;
    assign o_mat.valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_ang.valid};
        end
    end

    function automatic t_rot prep(input logic [ANGLE_BITS-1:0] raw);
        t_rot r;
        t_cw  a;
        a = t_cw'($signed(raw)) <<< (30 - (ANGLE_BITS - 3));
        if (a > PI_Q30) a = PI_Q30;
        if (a < -PI_Q30) a = -PI_Q30;
        r.neg = 1'b0;
        if (a > HALF_PI_Q30) begin
            a = a - PI_Q30;
            r.neg = 1'b1;
        end else if (a < -HALF_PI_Q30) begin
            a = a + PI_Q30;
            r.neg = 1'b1;
        end
        r.x = GAIN_Q30;
        r.y = '0;
        r.z = a;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prep.roll  <= prep(i_ang.data[0 +: ANGLE_BITS]);
            r_prep.pitch <= prep(i_ang.data[ANGLE_BITS +: ANGLE_BITS]);
            r_prep.yaw   <= prep(i_ang.data[2*ANGLE_BITS +: ANGLE_BITS]);
        end
    end

    assign cells[0] = r_prep;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ear_cell u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_step(STEP_BITS'(g)),
            .i_cell(cells[g]),
            .o_cell(cells[g+1])
        );
    end

    ear_mat u_mat (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_cell(cells[CORDIC_STEPS]),
        .o_mat (o_mat.data)
    );
endmodule

### src/ear_cell.sv
// One CORDIC micro-rotation for all three angles; step index is tied per cell.
// Depends on ear_pkg.
module ear_cell import ear_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [STEP_BITS-1:0] i_step,
    input  t_cell                i_cell,
    output t_cell                o_cell
);
    function automatic t_rot rot(input t_rot a);
        t_rot r;
        r = a;
        if (!a.z[CW-1]) begin
            r.x = a.x - (a.y >>> i_step);
            r.y = a.y + (a.x >>> i_step);
            r.z = a.z - atan_q30(int'(i_step));
        end else begin
            r.x = a.x + (a.y >>> i_step);
            r.y = a.y - (a.x >>> i_step);
            r.z = a.z + atan_q30(int'(i_step));
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cell.roll  <= rot(i_cell.roll);
            o_cell.pitch <= rot(i_cell.pitch);
            o_cell.yaw   <= rot(i_cell.yaw);
        end
    end
endmodule

### src/ear_mat.sv
// Matrix stages: round sin/cos to Q20, form products, round and saturate.
// Depends on ear_pkg.
module ear_mat import ear_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,       // stage advance, shared by all pipeline register levels
    input  t_cell i_cell,
    output logic [9*OUT_BITS-1:0] o_mat
);
    t_sc r_cr, r_sr, r_cp, r_sp, r_cy, r_sy;
    logic signed [43:0] r_cycp, r_sysr, r_cysp, r_cysr, r_sysp, r_sycr, r_cpcr, r_cpsr,
                        r_sycp, r_cycr, r_sp40;
    t_sc r_cr2, r_sr2;
    logic signed [65:0] r_e [9];

    function automatic t_sc rnd(input t_cw v, input logic neg);
        t_cw t;
        t_sc s;
        t = (v + 34'sd512) >>> 10;
        s = t[SCW-1:0];
        return neg ? -s : s;
    endfunction

    function automatic logic [OUT_BITS-1:0] q14(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + (66'sd1 <<< 45)) >>> 46;
        if (r > 66'sd16384) r = 66'sd16384;
        if (r < -66'sd16384) r = -66'sd16384;
        return r[OUT_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr <= rnd(i_cell.roll.x,  i_cell.roll.neg);
            r_sr <= rnd(i_cell.roll.y,  i_cell.roll.neg);
            r_cp <= rnd(i_cell.pitch.x, i_cell.pitch.neg);
            r_sp <= rnd(i_cell.pitch.y, i_cell.pitch.neg);
            r_cy <= rnd(i_cell.yaw.x,   i_cell.yaw.neg);
            r_sy <= rnd(i_cell.yaw.y,   i_cell.yaw.neg);
            // pair products, Q40
            r_cycp <= r_cy * r_cp;
            r_sysr <= r_sy * r_sr;
            r_cysp <= r_cy * r_sp;
            r_cysr <= r_cy * r_sr;
            r_sysp <= r_sy * r_sp;
            r_sycr <= r_sy * r_cr;
            r_cpcr <= r_cp * r_cr;
            r_cpsr <= r_cp * r_sr;
            r_sycp <= r_sy * r_cp;
            r_cycr <= r_cy * r_cr;
            r_sp40 <= 44'(r_sp) <<< 20;
            r_cr2  <= r_cr;
            r_sr2  <= r_sr;
            // Q60 elements
            r_e[0] <= 66'(r_cycp) <<< 20;
            r_e[1] <= (66'(r_sysr) <<< 20) - r_cysp * r_cr2;
            r_e[2] <= r_cysp * r_sr2 + (66'(r_sycr) <<< 20);
            r_e[3] <= 66'(r_sp40) <<< 20;
            r_e[4] <= 66'(r_cpcr) <<< 20;
            r_e[5] <= -(66'(r_cpsr) <<< 20);
            r_e[6] <= -(66'(r_sycp) <<< 20);
            r_e[7] <= r_sysp * r_cr2 + (66'(r_cysr) <<< 20);
            r_e[8] <= (66'(r_cycr) <<< 20) - r_sysp * r_sr2;
            for (int k = 0; k < 9; k++) o_mat[k*OUT_BITS +: OUT_BITS] <= q14(r_e[k]);
        end
    end
endmodule
